>>> rtl/kee_pkg.sv
// ----------------------------------------------------------------------------
// kee_pkg
// Shared widths, reset values, command codes and word types of the key edge
// event queue.
// ----------------------------------------------------------------------------
package kee_pkg;

	localparam int KEY_W          = 8;
	localparam int CNT_W          = 4;
	localparam int KEYS_W         = 64;
	localparam int STAMP_W        = 32;
	localparam int LP_W           = 16;
	localparam int MASK_W         = 8;
	localparam int HELD_SLOTS_DEF = 8;
	localparam int FIFO_DEPTH_DEF = 16;

	localparam logic [LP_W-1:0] LONG_PRESS_RST = 16'd600;

	localparam logic CMD_SCAN = 1'b0;
	localparam logic CMD_POP  = 1'b1;

	typedef logic [KEY_W-1:0] key_t;
	typedef logic [LP_W-1:0]  cfg_t;

	typedef struct packed {
		logic               cmd;
		logic               changed;
		logic               enter_level;
		logic               delete_level;
		logic [CNT_W-1:0]   held_count;
		logic [KEYS_W-1:0]  held_keys;
		logic [STAMP_W-1:0] now_ms;
	} item_t;

	typedef struct packed {
		logic [MASK_W-1:0] new_key_mask;
		logic              enter_pressed;
		logic              delete_pressed;
		logic              enter_long;
		logic [KEY_W-1:0]  popped_char;
		logic              queue_was_empty;
	} result_t;

endpackage

>>> rtl/kee_stream_if.sv
// ----------------------------------------------------------------------------
// kee_stream_if
// Valid/ready channel carrying one word of a chosen payload type.
// ----------------------------------------------------------------------------
interface kee_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/key_edge_event_queue.sv
// ----------------------------------------------------------------------------
// key_edge_event_queue
// Key press edge detector with a character queue, long-press and
// enter/delete edge events.
// ----------------------------------------------------------------------------
// Steps: a pop word passes through exec and emit; a scan word passes through exec,
//   one push step per newly pressed slot (up to HELD_SLOTS), then emit.
// Throughput: one word at a time; the serial queue write pass and output back-pressure set the rate.
// Reset: arst_n clears control state, pointers and the long-press register
//   to 600 ms at once; there is no clearing pass.
module key_edge_event_queue #(
	parameter int HELD_SLOTS = kee_pkg::HELD_SLOTS_DEF,
	parameter int FIFO_DEPTH = kee_pkg::FIFO_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	kee_stream_if.sink   req,
	kee_stream_if.source rsp,
	kee_stream_if.sink   cfg
);

	localparam int SLOT_W = (HELD_SLOTS > 1) ? $clog2(HELD_SLOTS) : 1;
	localparam int KEY_W  = kee_pkg::KEY_W;
	localparam int CNT_W  = kee_pkg::CNT_W;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_EXEC = 4'b0010,
		ST_PUSH = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	state_t state_q;

	kee_pkg::cfg_t   long_ms_q;
	kee_pkg::item_t  item_s1;
	kee_pkg::result_t out_q;
	logic            out_valid_q;

	kee_pkg::key_t    held_q [HELD_SLOTS];
	logic [CNT_W-1:0] held_n_q;
	logic             enter_q;
	logic             delete_q;
	logic [kee_pkg::STAMP_W-1:0] stamp_q;
	logic             fired_q;

	kee_pkg::key_t        keys_s2 [HELD_SLOTS];
	logic [HELD_SLOTS-1:0] mask_s2;
	logic [HELD_SLOTS-1:0] rem_q;
	logic                 e_edge_s2;
	logic                 d_edge_s2;
	logic                 lp_s2;
	logic                 empty_s2;

	kee_pkg::key_t        cur [HELD_SLOTS];
	logic [CNT_W-1:0]     cur_n;
	logic [HELD_SLOTS-1:0] lane_new;
	logic                 cur_enter;
	logic                 cur_del;
	logic                 e_edge;
	logic [kee_pkg::STAMP_W-1:0] stamp_eff;
	logic [kee_pkg::STAMP_W-1:0] held_for;
	logic                 fired_eff;
	logic                 fire;

	logic [SLOT_W-1:0]    sel;
	logic                 fifo_push;
	logic                 fifo_pop;
	logic                 fifo_full;
	logic                 fifo_empty;
	kee_pkg::key_t        fifo_rd;
	logic                 load_out;
	logic [kee_pkg::MASK_W-1:0] mask_ext;
	logic                 is_exec;
	logic                 is_pop;

	assign req.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	assign is_exec = (state_q == ST_EXEC);
	assign is_pop  = (item_s1.cmd == kee_pkg::CMD_POP);

	// Current frame: fresh fields when changed, otherwise the stored set.
	always_comb begin
		for (int i = 0; i < HELD_SLOTS; i++) begin
			cur[i] = item_s1.changed ? item_s1.held_keys[KEY_W*i +: KEY_W] : held_q[i];
		end
		if (item_s1.changed) begin
			cur_n = (item_s1.held_count > CNT_W'(HELD_SLOTS)) ? CNT_W'(HELD_SLOTS)
			                                                  : item_s1.held_count;
			cur_enter = item_s1.enter_level;
			cur_del   = item_s1.delete_level;
		end else begin
			cur_n     = held_n_q;
			cur_enter = enter_q;
			cur_del   = delete_q;
		end
	end

	for (genvar g = 0; g < HELD_SLOTS; g++) begin : g_lane
		kee_lane #(
			.HELD_SLOTS(HELD_SLOTS)
		) u_lane (
			.code      (cur[g]),
			.slot_valid(CNT_W'(g) < cur_n),
			.prev_keys (held_q),
			.prev_n    (held_n_q),
			.is_new    (lane_new[g])
		);
	end

	// Long-press timing. A zero down-stamp means no hold is being timed.
	assign e_edge    = cur_enter && !enter_q;
	assign stamp_eff = e_edge ? item_s1.now_ms : stamp_q;
	assign fired_eff = e_edge ? 1'b0 : fired_q;
	assign held_for  = item_s1.now_ms - stamp_eff;
	assign fire      = cur_enter && (stamp_eff != '0) && !fired_eff &&
	                   (held_for >= {{(kee_pkg::STAMP_W-kee_pkg::LP_W){1'b0}}, long_ms_q});

	// Merge: push the lowest remaining new slot each cycle.
	always_comb begin
		sel = '0;
		for (int i = HELD_SLOTS - 1; i >= 0; i--) begin
			if (rem_q[i]) begin
				sel = SLOT_W'(i);
			end
		end
	end

	assign fifo_push = (state_q == ST_PUSH);
	assign fifo_pop  = is_exec && is_pop;

	kee_fifo #(
		.DEPTH(FIFO_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (fifo_push),
		.push_data(keys_s2[sel]),
		.pop      (fifo_pop),
		.full     (fifo_full),
		.empty    (fifo_empty),
		.rd_data  (fifo_rd)
	);

	assign load_out = (state_q == ST_EMIT) && (!out_valid_q || rsp.ready);

	always_comb begin
		mask_ext = '0;
		mask_ext[HELD_SLOTS-1:0] = mask_s2;
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1 <= req.data;
		end
		if (is_exec) begin
			keys_s2   <= cur;
			mask_s2   <= lane_new;
			e_edge_s2 <= e_edge;
			d_edge_s2 <= cur_del && !delete_q;
			lp_s2     <= fire;
			empty_s2  <= fifo_empty;
			if (!is_pop && item_s1.changed) begin
				held_q <= cur;
			end
		end
		if (load_out) begin
			if (is_pop) begin
				out_q.new_key_mask    <= '0;
				out_q.enter_pressed   <= 1'b0;
				out_q.delete_pressed  <= 1'b0;
				out_q.enter_long      <= 1'b0;
				out_q.popped_char     <= empty_s2 ? '0 : fifo_rd;
				out_q.queue_was_empty <= empty_s2;
			end else begin
				out_q.new_key_mask    <= mask_ext;
				out_q.enter_pressed   <= e_edge_s2;
				out_q.delete_pressed  <= d_edge_s2;
				out_q.enter_long      <= lp_s2;
				out_q.popped_char     <= '0;
				out_q.queue_was_empty <= 1'b0;
			end
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			long_ms_q   <= kee_pkg::LONG_PRESS_RST;
			out_valid_q <= 1'b0;
			held_n_q    <= '0;
			enter_q     <= 1'b0;
			delete_q    <= 1'b0;
			stamp_q     <= '0;
			fired_q     <= 1'b0;
			rem_q       <= '0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				long_ms_q <= cfg.data;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (is_pop) begin
						state_q <= ST_EMIT;
					end else begin
						held_n_q <= cur_n;
						enter_q  <= cur_enter;
						delete_q <= cur_del;
						stamp_q  <= cur_enter ? stamp_eff : '0;
						fired_q  <= fire || fired_eff;
						rem_q    <= lane_new;
						state_q  <= (lane_new != '0) ? ST_PUSH : ST_EMIT;
					end
				end
				ST_PUSH: begin
					rem_q[sel] <= 1'b0;
					if ((rem_q & (rem_q - 1'b1)) == '0) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_push_pass_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PUSH) |-> (rem_q != '0))
		else $error("key_edge_event_queue: push pass with no slot left");
	a_empty_pop_gives_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.queue_was_empty) |-> (out_q.popped_char == '0))
		else $error("key_edge_event_queue: empty pop returned a character");
	a_result_only_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_EMIT))
		else $error("key_edge_event_queue: result raised outside the emit step");
	a_pop_word_no_events: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.queue_was_empty) |->
		(out_q.new_key_mask == '0 && !out_q.enter_long))
		else $error("key_edge_event_queue: pop result carries key events");
`endif

endmodule

>>> rtl/kee_lane.sv
// ----------------------------------------------------------------------------
// kee_lane
// One slot lane: flags the slot's code as new when it is valid and absent
// from the previous frame's key set.
// ----------------------------------------------------------------------------
module kee_lane #(
	parameter int HELD_SLOTS = kee_pkg::HELD_SLOTS_DEF
) (
	input  kee_pkg::key_t            code,
	input  logic                     slot_valid,
	input  kee_pkg::key_t            prev_keys [HELD_SLOTS],
	input  logic [kee_pkg::CNT_W-1:0] prev_n,
	output logic                     is_new
);

	logic [HELD_SLOTS-1:0] hit;

	always_comb begin
		for (int j = 0; j < HELD_SLOTS; j++) begin
			hit[j] = (kee_pkg::CNT_W'(j) < prev_n) && (prev_keys[j] == code);
		end
	end

	assign is_new = slot_valid && (hit == '0);

endmodule

>>> rtl/kee_fifo.sv
// ----------------------------------------------------------------------------
// kee_fifo
// Character queue in a small memory with a registered read port. A push into
// a full queue is dropped, so at most DEPTH - 1 characters are held.
// ----------------------------------------------------------------------------
module kee_fifo #(
	parameter int DEPTH = kee_pkg::FIFO_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  kee_pkg::key_t push_data,
	input  logic          pop,
	output logic          full,
	output logic          empty,
	output kee_pkg::key_t rd_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

	kee_pkg::key_t    mem [DEPTH];
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] wr_nxt;
	logic [PTR_W-1:0] rd_nxt;
	kee_pkg::key_t    rd_data_q;

	assign wr_nxt  = (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
	assign rd_nxt  = (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
	assign full    = (wr_nxt == rd_ptr_q);
	assign empty   = (wr_ptr_q == rd_ptr_q);
	assign rd_data = rd_data_q;

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem[wr_ptr_q] <= push_data;
		end
		if (pop && !empty) begin
			rd_data_q <= mem[rd_ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= wr_nxt;
			end
			if (pop && !empty) begin
				rd_ptr_q <= rd_nxt;
			end
		end
	end

`ifndef SYNTHESIS
	a_no_push_pop_same_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && pop))
		else $error("kee_fifo: push and pop in the same cycle");
	a_full_holds_wr_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		(push && full && !pop) |=> $stable(wr_ptr_q))
		else $error("kee_fifo: dropped push moved the write pointer");
	a_empty_holds_rd_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && empty && !push) |=> $stable(rd_ptr_q))
		else $error("kee_fifo: pop of an empty queue moved the read pointer");
`endif

endmodule
